// ===== rtl/lfte_pkg.sv =====
// lfte_pkg: shared constants and types for the line flag table engine.
// No dependencies.
package lfte_pkg;
	localparam int unsigned MaxLinesDef = 4096;
	localparam int unsigned FlagBitsDef = 32;
	localparam int unsigned LineW = 13;
	localparam int unsigned WordW = 32;

	typedef enum logic [2:0] {
		OP_MARK   = 3'd0,
		OP_FIND   = 3'd1,
		OP_READ   = 3'd2,
		OP_RANGE  = 3'd3,
		OP_SEARCH = 3'd4
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [1:0] REG_COUNT = 2'd0;
	localparam logic [1:0] REG_UMASK = 2'd1;
	localparam logic [1:0] REG_PROT = 2'd2;
	localparam logic [1:0] REG_PEN = 2'd3;
endpackage

// ===== rtl/line_flag_table_engine.sv =====
// line_flag_table_engine: top level, sequencer around one flag RAM.
// Depends on lfte_pkg and lfte_ram.
//
// channel | dir | handshake     | payload
// in      | in  | valid/ready   | op, line, end_line, set_mark, toggle_all, marker, masks, mode
// out     | out | out_valid/rdy | status, was_marked, found_line, flags_read, lines_changed
// cfg     | in  | APB           | four registers at 4*i
//
// After reset a clearing pass writes every RAM entry; no beat is taken during it.
// Each line an item visits passes through the read, wait and exec states, after the accept
// state and before the result state; a toggle with an in-range line visits that line
// once more.
// The RAM port is the shared resource; one line is handled per step.
// in_ready is low while an item is at work or its result is not yet taken.
module line_flag_table_engine
	import lfte_pkg::*;
#(
	parameter int unsigned MAX_LINES = MaxLinesDef,
	parameter int unsigned FLAG_BITS = FlagBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           op,
	input  logic [LineW-1:0]     line,
	input  logic [LineW-1:0]     end_line,
	input  logic                 set_mark,
	input  logic                 toggle_all,
	input  logic [WordW-1:0]     marker,
	input  logic [WordW-1:0]     keep_mask,
	input  logic [WordW-1:0]     set_bits,
	input  logic [WordW-1:0]     match_value,
	input  logic [3:0]           search_mode,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic                 was_marked,
	output logic [LineW-1:0]     found_line,
	output logic [WordW-1:0]     flags_read,
	output logic [LineW-1:0]     lines_changed,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	localparam int unsigned AW = $clog2(MAX_LINES);
	localparam int unsigned CW = $clog2(MAX_LINES + 2) + 1;
	localparam logic [WordW-1:0] FMASK = WordW'((64'd1 << FLAG_BITS) - 64'd1);

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_WAIT, S_EXEC, S_DONE} state_t;

	state_t state_q;
	logic [LineW-1:0] cnt_reg_q;
	logic [WordW-1:0] umask_q, prot_q;
	logic pen_q;
	logic [2:0] op_q;
	logic [CW-1:0] cur_q, stop_q;
	logic setm_q, togg_q, back_q, eq_q, sgl_q;
	logic [WordW-1:0] mk_q, am_q, ov_q, mv_q;
	logic [1:0] st_q;
	logic was_q;
	logic [LineW-1:0] found_q, chg_q;
	logic [WordW-1:0] rd_q;

	logic we;
	logic [AW-1:0] addr;
	logic [WordW-1:0] wdata, rdata;

	lfte_ram #(.Width(WordW), .Depth(MAX_LINES)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[3:2])
			REG_COUNT: prdata = 32'(cnt_reg_q);
			REG_UMASK: prdata = umask_q;
			REG_PROT:  prdata = prot_q;
			default:   prdata = 32'(pen_q);
		endcase
	end

	logic [CW-1:0] lcnt, ln, en, s0, e0, clampe;
	logic mk_ok, is_line;
	assign lcnt = (CW'(cnt_reg_q) > CW'(MAX_LINES)) ? CW'(MAX_LINES) : CW'(cnt_reg_q);
	assign ln = CW'(line);
	assign en = CW'(end_line);
	assign mk_ok = (marker != '0) && ((marker & (marker - 1'b1)) == '0)
		&& ((marker & umask_q & FMASK) != '0);
	assign is_line = (ln >= CW'(1)) && (ln <= lcnt);
	assign s0 = (ln > en) ? en : ln;
	assign e0 = (ln > en) ? ln : en;
	assign clampe = (e0 > lcnt + CW'(1)) ? lcnt + CW'(1) : e0;

	logic [WordW-1:0] v, nv;
	logic hit;
	assign v = rdata & FMASK;
	always_comb begin
		hit = 1'b0;
		nv = v;
		unique case (op_q)
			OP_MARK:   nv = sgl_q ? (togg_q ? v : (setm_q ? (v | mk_q) : (v & ~mk_q)))
				: (v ^ mk_q);
			OP_FIND: begin
				hit = (v & mk_q) != '0;
				nv = v & ~mk_q;
			end
			OP_RANGE:  nv = (v & am_q) | ov_q;
			default:   hit = eq_q ? (((v & am_q) | ov_q) == mv_q) : ((v & am_q) != '0);
		endcase
		nv = nv & FMASK;
	end

	assign addr = AW'(cur_q - CW'(1));
	assign we = (state_q == S_CLR) || ((state_q == S_EXEC)
		&& ((op_q == OP_MARK) || (op_q == OP_RANGE) || ((op_q == OP_FIND) && hit)));
	assign wdata = (state_q == S_CLR) ? '0 : nv;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign status = st_q;
	assign was_marked = was_q;
	assign found_line = found_q;
	assign flags_read = rd_q;
	assign lines_changed = chg_q;

	logic [CW-1:0] fs_rng, fs_bk, fs_fw;
	logic [3:0] kind;
	assign kind = {search_mode[3:2], 2'b00};
	assign fs_rng = (s0 < CW'(1)) ? CW'(1) : s0;
	assign fs_bk = (ln > lcnt) ? lcnt : ln;
	assign fs_fw = (ln < CW'(1)) ? CW'(1) : ln;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_reg_q <= '0;
			umask_q <= 32'h0000FFFF;
			prot_q <= 32'hFFFF0000;
			pen_q <= 1'b1;
			cur_q <= CW'(1);
		end else begin
			if (psel && penable && pwrite) begin
				unique case (paddr[3:2])
					REG_COUNT: cnt_reg_q <= pwdata[LineW-1:0];
					REG_UMASK: umask_q <= pwdata;
					REG_PROT:  prot_q <= pwdata;
					default:   pen_q <= pwdata[0];
				endcase
			end
			unique case (state_q)
				S_CLR: begin
					if (cur_q == CW'(MAX_LINES)) state_q <= S_IDLE;
					else cur_q <= cur_q + CW'(1);
				end
				S_IDLE: if (in_valid) begin
					op_q <= op; mk_q <= marker; setm_q <= set_mark; togg_q <= toggle_all;
					mv_q <= match_value; eq_q <= search_mode[2];
					back_q <= search_mode[1];
					st_q <= ST_OK; was_q <= 1'b0; found_q <= '0; rd_q <= '0; chg_q <= '0;
					state_q <= S_DONE;
					am_q <= keep_mask; ov_q <= set_bits;
					sgl_q <= 1'b0;
					unique case (op)
						OP_MARK: begin
							if (!mk_ok) st_q <= ST_INVALID;
							else begin
								if (!is_line) st_q <= ST_RANGE;
								if (is_line) begin
									sgl_q <= 1'b1; cur_q <= ln; stop_q <= ln;
									state_q <= S_RD;
								end else if (toggle_all && lcnt != '0) begin
									cur_q <= CW'(1); stop_q <= lcnt; state_q <= S_RD;
								end
							end
						end
						OP_FIND: begin
							if (!mk_ok) st_q <= ST_INVALID;
							else begin
								st_q <= ST_NOTFOUND;
								if (ln + CW'(1) <= lcnt) begin
									cur_q <= ln + CW'(1); stop_q <= lcnt; state_q <= S_RD;
								end
							end
						end
						OP_READ: begin
							if (!is_line) st_q <= ST_RANGE;
							else begin cur_q <= ln; stop_q <= ln; state_q <= S_RD; end
						end
						OP_RANGE: begin
							if (pen_q) begin
								am_q <= keep_mask | prot_q; ov_q <= set_bits & ~prot_q;
							end
							if (fs_rng < clampe) begin
								cur_q <= fs_rng; stop_q <= clampe - CW'(1); state_q <= S_RD;
							end
						end
						OP_SEARCH: begin
							if (kind == 4'h0 || kind == 4'hC || search_mode[1:0] == 2'b11
								|| keep_mask == '0) st_q <= ST_INVALID;
							else begin
								st_q <= ST_NOTFOUND;
								if (search_mode[1]) begin
									if (fs_bk >= CW'(1)) begin
										cur_q <= fs_bk; stop_q <= CW'(1); state_q <= S_RD;
									end
								end else begin
									if (fs_fw <= lcnt) begin
										cur_q <= fs_fw; stop_q <= lcnt; state_q <= S_RD;
									end
								end
							end
						end
						default: st_q <= ST_INVALID;
					endcase
				end
				S_RD: state_q <= S_WAIT;
				S_WAIT: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_RD;
					unique case (op_q)
						OP_MARK: begin
							if (sgl_q) begin
								was_q <= (v & mk_q) != '0;
								if (togg_q && lcnt != '0) begin
									sgl_q <= 1'b0; cur_q <= CW'(1); stop_q <= lcnt;
								end else state_q <= S_DONE;
							end else if (cur_q == stop_q) state_q <= S_DONE;
							else cur_q <= cur_q + CW'(1);
						end
						OP_READ: begin rd_q <= v; state_q <= S_DONE; end
						OP_RANGE: begin
							chg_q <= chg_q + LineW'(1);
							if (cur_q == stop_q) state_q <= S_DONE;
							else cur_q <= cur_q + CW'(1);
						end
						default: begin
							if (hit) begin
								st_q <= ST_OK; found_q <= LineW'(cur_q); state_q <= S_DONE;
							end else if (cur_q == stop_q) state_q <= S_DONE;
							else if (op_q == OP_SEARCH && back_q) cur_q <= cur_q - CW'(1);
							else cur_q <= cur_q + CW'(1);
						end
					endcase
				end
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/lfte_ram.sv =====
// lfte_ram: generic single-port RAM with registered read.
// No dependencies.
module lfte_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/lfte_checker.sv =====
// lfte_checker: port-level assertions for line_flag_table_engine.
// Depends on lfte_pkg; bound to the top level.
module lfte_checker
	import lfte_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [12:0] found_line,
	input logic [31:0] flags_read
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result beat dropped");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> found_line == '0)
		else $error("found line without ok");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after beat");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE |-> flags_read == '0)
		else $error("flags on bad line");
endmodule

bind line_flag_table_engine lfte_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.found_line(found_line), .flags_read(flags_read)
);
